FILE: design/pwli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear table interpolation: shared definitions
// Widths, status codes, register indexes and operation codes of the
// interpolation block; its divider uses only the arithmetic widths.
// ----------------------------------------------------------------------------
package pwli_pkg;

  // Table geometry.
  localparam int TableDepth = 64;
  localparam int AddrW      = $clog2(TableDepth);

  // Field widths.
  localparam int OpW    = 1;
  localparam int AzW    = 17;
  localparam int ResW   = 16;
  localparam int SlowW  = 13;
  localparam int CntW   = 7;
  localparam int StatW  = 2;

  // Interpolation arithmetic widths.
  localparam int DenW  = AzW + 1;          // difference of two azimuths
  localparam int DresW = ResW + 1;         // difference of two residuals
  localparam int NumW  = DenW + DresW;     // product of the two differences
  localparam int QuotW = NumW + 1;         // signed quotient
  localparam int SumW  = QuotW + 1;        // left residual plus quotient

  // One table entry: azimuth in the upper bits, residual in the lower.
  localparam int EntryW = AzW + ResW;

  // Configuration port.
  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  // Operation codes.
  localparam logic [OpW-1:0] OpLoad  = 1'b0;
  localparam logic [OpW-1:0] OpQuery = 1'b1;

  // Register indexes.
  localparam logic [1:0] RegEntryCount = 2'd0;
  localparam logic [1:0] RegMinSlow    = 2'd1;
  localparam logic [1:0] RegMaxSlow    = 2'd2;

  // Reset values of the registers.
  localparam logic [CntW-1:0]  EntryCountRst = 7'd2;
  localparam logic [SlowW-1:0] MinSlowRst    = 13'd0;
  localparam logic [SlowW-1:0] MaxSlowRst    = 13'd5000;

  // Result status codes.
  localparam logic [StatW-1:0] StOk      = 2'd0;
  localparam logic [StatW-1:0] StNoTable = 2'd1;
  localparam logic [StatW-1:0] StAzRange = 2'd2;
  localparam logic [StatW-1:0] StOverrun = 2'd3;

endpackage

FILE: design/pwli_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear table interpolation: signed divider
// Restoring division of magnitudes, one quotient bit per cycle, with the sign
// applied at the end so that the quotient truncates toward zero.
// ----------------------------------------------------------------------------
module pwli_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [pwli_pkg::NumW-1:0]      num_i,
  input  logic signed [pwli_pkg::DenW-1:0]      den_i,
  output logic                                  done_o,
  output logic signed [pwli_pkg::QuotW-1:0]     quot_o
);

  localparam int CntBits = $clog2(pwli_pkg::NumW);
  localparam logic [CntBits-1:0] LastStep = CntBits'(pwli_pkg::NumW - 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntBits-1:0]            cnt_q, cnt_d;
  logic [pwli_pkg::NumW-1:0]     dvd_q, dvd_d;
  logic [pwli_pkg::DenW-1:0]     rem_q, rem_d;
  logic [pwli_pkg::DenW-1:0]     dmag_q, dmag_d;
  logic                          neg_q, neg_d;
  logic [pwli_pkg::DenW:0]       trial;
  logic                          qbit;
  logic [pwli_pkg::NumW-1:0]     num_mag;
  logic [pwli_pkg::DenW-1:0]     den_mag;

  // Magnitudes of the operands; the most negative value maps onto its
  // unsigned magnitude.
  assign num_mag = num_i[pwli_pkg::NumW-1] ? pwli_pkg::NumW'(-num_i) : num_i;
  assign den_mag = den_i[pwli_pkg::DenW-1] ? pwli_pkg::DenW'(-den_i) : den_i;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_q, dvd_q[pwli_pkg::NumW-1]};
  assign qbit  = (trial >= {1'b0, dmag_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = num_mag;
      rem_d  = '0;
      dmag_d = den_mag;
      neg_d  = num_i[pwli_pkg::NumW-1] ^ den_i[pwli_pkg::DenW-1];
    end else if (busy_q) begin
      rem_d = qbit ? pwli_pkg::DenW'(trial - {1'b0, dmag_q})
                   : trial[pwli_pkg::DenW-1:0];
      dvd_d = {dvd_q[pwli_pkg::NumW-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
  end

  // After the last step the dividend register holds the quotient magnitude.
  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

endmodule

FILE: design/piecewise_linear_table_interp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear table interpolation
// Holds one table of ascending azimuth breakpoints with residual times and
// interpolates a residual for a queried azimuth and slowness.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                        Carries
//  -------  -------------------------------  ----------------------------------
//  in       in_valid_i / in_stall_o          op, entry_index, azimuth,
//                                            residual_value, slowness
//  out      out_valid_o / out_stall_i        residual, status
//  cfg      psel, penable, pwrite, pready    entry_count, min_slowness,
//                                            max_slowness
//
// A load writes the table memory at acceptance and does not stall the input.
// A query steps through RDLAST, CHK, SEARCH (k breakpoints, 1 to entries in
// use - 1, one entry a cycle from the read port), MUL, DIVS, DIV (bit-serial
// divider) and WB; the input stalls until the sequencer is back in idle, so the
// next item can be taken in the cycle after the result enters the output
// register. Queries that fail the slowness or azimuth range check go straight
// to WB; equal breakpoints skip the divider.
// The table holds no reset value; reset sets only control and config registers.
// A finished result waits in the output register while the next item is taken;
// while that register is still full and stalled, the next query holds its result.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [pwli_pkg::OpW-1:0]               op_i,
  input  logic [pwli_pkg::AddrW-1:0]             entry_index_i,
  input  logic signed [pwli_pkg::AzW-1:0]        azimuth_i,
  input  logic signed [pwli_pkg::ResW-1:0]       residual_value_i,
  input  logic [pwli_pkg::SlowW-1:0]             slowness_i,
  // Output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pwli_pkg::ResW-1:0]       residual_o,
  output logic [pwli_pkg::StatW-1:0]             status_o,
  // Configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [pwli_pkg::PaddrW-1:0]            paddr,
  input  logic [pwli_pkg::PdataW-1:0]            pwdata,
  output logic [pwli_pkg::PdataW-1:0]            prdata,
  output logic                                   pready
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_RDLAST = 8'b0000_0010,
    ST_CHK    = 8'b0000_0100,
    ST_SEARCH = 8'b0000_1000,
    ST_MUL    = 8'b0001_0000,
    ST_DIVS   = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_WB     = 8'b1000_0000
  } state_e;

  state_e                              state_q, state_d;

  logic [pwli_pkg::CntW-1:0]           entry_count_q;
  logic [pwli_pkg::SlowW-1:0]          min_slow_q;
  logic [pwli_pkg::SlowW-1:0]          max_slow_q;

  logic [pwli_pkg::EntryW-1:0]         mem_q [pwli_pkg::TableDepth];
  logic [pwli_pkg::EntryW-1:0]         rd_data_q;
  logic [pwli_pkg::AddrW-1:0]          rd_addr;
  logic                                mem_we;

  logic signed [pwli_pkg::AzW-1:0]     az_q, az_d;
  logic [pwli_pkg::CntW-1:0]           n_q, n_d;
  logic [pwli_pkg::AddrW-1:0]          idx_q, idx_d;
  logic signed [pwli_pkg::AzW-1:0]     first_az_q, first_az_d;
  logic signed [pwli_pkg::AzW-1:0]     prev_az_q, prev_az_d;
  logic signed [pwli_pkg::ResW-1:0]    prev_res_q, prev_res_d;
  logic signed [pwli_pkg::AzW-1:0]     cur_az_q, cur_az_d;
  logic signed [pwli_pkg::ResW-1:0]    cur_res_q, cur_res_d;
  logic signed [pwli_pkg::NumW-1:0]    num_q, num_d;
  logic signed [pwli_pkg::DenW-1:0]    den_q, den_d;
  logic signed [pwli_pkg::ResW-1:0]    res_q, res_d;
  logic [pwli_pkg::StatW-1:0]          stat_q, stat_d;

  logic                                out_valid_q, out_valid_d;
  logic signed [pwli_pkg::ResW-1:0]    out_res_q, out_res_d;
  logic [pwli_pkg::StatW-1:0]          out_stat_q, out_stat_d;

  logic                                in_acc;
  logic                                out_free;
  logic                                cfg_we;
  logic [pwli_pkg::CntW-1:0]           n_clamp;
  logic [pwli_pkg::AddrW-1:0]          last_idx;
  logic signed [pwli_pkg::AzW-1:0]     rd_az;
  logic signed [pwli_pkg::ResW-1:0]    rd_res;
  logic signed [pwli_pkg::DenW-1:0]    daz;
  logic signed [pwli_pkg::DresW-1:0]   dres;
  logic signed [pwli_pkg::SumW-1:0]    sum;
  logic                                div_start;
  logic                                div_done;
  logic signed [pwli_pkg::QuotW-1:0]   div_quot;

  // Handshake decode.
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= pwli_pkg::EntryCountRst;
      min_slow_q    <= pwli_pkg::MinSlowRst;
      max_slow_q    <= pwli_pkg::MaxSlowRst;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        pwli_pkg::RegEntryCount: entry_count_q <= pwdata[pwli_pkg::CntW-1:0];
        pwli_pkg::RegMinSlow:    min_slow_q    <= pwdata[pwli_pkg::SlowW-1:0];
        pwli_pkg::RegMaxSlow:    max_slow_q    <= pwdata[pwli_pkg::SlowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pwli_pkg::RegEntryCount: prdata = pwli_pkg::PdataW'(entry_count_q);
      pwli_pkg::RegMinSlow:    prdata = pwli_pkg::PdataW'(min_slow_q);
      pwli_pkg::RegMaxSlow:    prdata = pwli_pkg::PdataW'(max_slow_q);
      default:                 prdata = '0;
    endcase
  end

  // Entries in use, held between 2 and the table depth.
  always_comb begin
    priority if (entry_count_q < pwli_pkg::CntW'(2)) begin
      n_clamp = pwli_pkg::CntW'(2);
    end else if (entry_count_q > pwli_pkg::CntW'(pwli_pkg::TableDepth)) begin
      n_clamp = pwli_pkg::CntW'(pwli_pkg::TableDepth);
    end else begin
      n_clamp = entry_count_q;
    end
  end

  assign last_idx = pwli_pkg::AddrW'(n_q - 1'b1);

  // Table memory: one write port for loads, one registered read port.
  assign mem_we = in_acc && (op_i == pwli_pkg::OpLoad);

  always_comb begin
    unique case (state_q)
      ST_RDLAST: rd_addr = last_idx;
      ST_CHK:    rd_addr = pwli_pkg::AddrW'(1);
      ST_SEARCH: rd_addr = idx_q + 1'b1;
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[entry_index_i] <= {azimuth_i, residual_value_i};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign rd_az  = $signed(rd_data_q[pwli_pkg::EntryW-1:pwli_pkg::ResW]);
  assign rd_res = $signed(rd_data_q[pwli_pkg::ResW-1:0]);

  // Azimuth past the left breakpoint, and residual step between the breakpoints.
  assign daz  = pwli_pkg::DenW'(az_q) - pwli_pkg::DenW'(prev_az_q);
  assign dres = pwli_pkg::DresW'(cur_res_q) - pwli_pkg::DresW'(prev_res_q);

  // Left residual plus the signed quotient, before saturation.
  assign sum = pwli_pkg::SumW'(prev_res_q) + pwli_pkg::SumW'(div_quot);

  assign div_start = (state_q == ST_DIVS) && (den_q != '0);

  pwli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Query sequencer: range checks, breakpoint walk, multiply and divide.
  always_comb begin
    state_d    = state_q;
    az_d       = az_q;
    n_d        = n_q;
    idx_d      = idx_q;
    first_az_d = first_az_q;
    prev_az_d  = prev_az_q;
    prev_res_d = prev_res_q;
    cur_az_d   = cur_az_q;
    cur_res_d  = cur_res_q;
    num_d      = num_q;
    den_d      = den_q;
    res_d      = res_q;
    stat_d     = stat_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (op_i == pwli_pkg::OpQuery)) begin
          az_d  = azimuth_i;
          n_d   = n_clamp;
          res_d = '0;
          if ((slowness_i < min_slow_q) || (slowness_i >= max_slow_q)) begin
            stat_d  = pwli_pkg::StNoTable;
            state_d = ST_WB;
          end else begin
            stat_d  = pwli_pkg::StOk;
            state_d = ST_RDLAST;
          end
        end
      end
      ST_RDLAST: begin
        // First entry is on the read port.
        first_az_d = rd_az;
        prev_az_d  = rd_az;
        prev_res_d = rd_res;
        state_d    = ST_CHK;
      end
      ST_CHK: begin
        // Last entry in use is on the read port.
        if ((az_q < first_az_q) || (az_q > rd_az)) begin
          stat_d  = pwli_pkg::StAzRange;
          state_d = ST_WB;
        end else begin
          idx_d   = pwli_pkg::AddrW'(1);
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // Entry idx_q is on the read port; the next one is already requested.
        if (rd_az < az_q) begin
          prev_az_d  = rd_az;
          prev_res_d = rd_res;
          if ((pwli_pkg::CntW'(idx_q) + 1'b1) >= n_q) begin
            stat_d  = pwli_pkg::StOverrun;
            state_d = ST_WB;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          cur_az_d  = rd_az;
          cur_res_d = rd_res;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        num_d   = daz * dres;
        den_d   = pwli_pkg::DenW'(cur_az_q) - pwli_pkg::DenW'(prev_az_q);
        state_d = ST_DIVS;
      end
      ST_DIVS: begin
        // Equal breakpoints give the left residual.
        if (den_q == '0) begin
          res_d   = prev_res_q;
          state_d = ST_WB;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          priority if (sum > pwli_pkg::SumW'(32767)) begin
            res_d = pwli_pkg::ResW'(32767);
          end else if (sum < -pwli_pkg::SumW'(32768)) begin
            res_d = pwli_pkg::ResW'(-32768);
          end else begin
            res_d = sum[pwli_pkg::ResW-1:0];
          end
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: loaded from the sequencer, emptied by the sink.
  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_WB) && out_free) begin
      out_valid_d = 1'b1;
      out_res_d   = res_q;
      out_stat_d  = stat_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= pwli_pkg::EntryCountRst;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    az_q       <= az_d;
    first_az_q <= first_az_d;
    prev_az_q  <= prev_az_d;
    prev_res_q <= prev_res_d;
    cur_az_q   <= cur_az_d;
    cur_res_q  <= cur_res_d;
    num_q      <= num_d;
    den_q      <= den_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    out_res_q  <= out_res_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o = out_valid_q;
  assign residual_o  = out_res_q;
  assign status_o    = out_stat_q;

`ifndef SYNTHESIS
  // An error result always carries a zero residual.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != pwli_pkg::StOk)) |-> (residual_o == '0))
    else $error("error result with non-zero residual");

  // The breakpoint walk never points past the entries in use.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (pwli_pkg::CntW'(idx_q) < n_q))
    else $error("search index beyond entries in use");

  // An accepted query always leaves the idle state.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op_i == pwli_pkg::OpQuery)) |=> (state_q != ST_IDLE))
    else $error("query accepted without starting the sequencer");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear table interpolation testbench
// Loads breakpoint tables, drives directed and random loads and queries
// across several register settings, and checks every interpolated residual
// and status against an independent prediction of the table search and the
// truncating interpolation.
// ----------------------------------------------------------------------------

// Mirrors the table and registers, works out the residual of each query and
// compares the block's results in order.
class residual_scoreboard;

  typedef struct packed {
    logic signed [pwli_pkg::ResW-1:0] residual;
    logic [pwli_pkg::StatW-1:0]       status;
  } interp_result_t;

  logic signed [pwli_pkg::AzW-1:0]  az_tab  [pwli_pkg::TableDepth];
  logic signed [pwli_pkg::ResW-1:0] res_tab [pwli_pkg::TableDepth];
  logic [pwli_pkg::CntW-1:0]        entry_count;
  logic [pwli_pkg::SlowW-1:0]       min_slow;
  logic [pwli_pkg::SlowW-1:0]       max_slow;
  interp_result_t                   residuals_due[$];
  int                               errors;

  function new();
    entry_count = pwli_pkg::EntryCountRst;
    min_slow    = pwli_pkg::MinSlowRst;
    max_slow    = pwli_pkg::MaxSlowRst;
    foreach (az_tab[k]) begin
      az_tab[k]  = '0;
      res_tab[k] = '0;
    end
    errors = 0;
  endfunction

  function void set_register(logic [1:0] index, logic [31:0] value);
    case (index)
      pwli_pkg::RegEntryCount: entry_count = value[pwli_pkg::CntW-1:0];
      pwli_pkg::RegMinSlow:    min_slow    = value[pwli_pkg::SlowW-1:0];
      pwli_pkg::RegMaxSlow:    max_slow    = value[pwli_pkg::SlowW-1:0];
      default: ;
    endcase
  endfunction

  // The entry count saturates to the range the table supports.
  function int used_entries();
    if (entry_count < 2) return 2;
    if (entry_count > pwli_pkg::TableDepth) return pwli_pkg::TableDepth;
    return int'(entry_count);
  endfunction

  function int pending();
    return residuals_due.size();
  endfunction

  // Applies a load, or works out the result a query is due to give.
  function void interpolate_item(logic [pwli_pkg::OpW-1:0]         op,
                                 logic [pwli_pkg::AddrW-1:0]       idx,
                                 logic signed [pwli_pkg::AzW-1:0]  az,
                                 logic signed [pwli_pkg::ResW-1:0] rv,
                                 logic [pwli_pkg::SlowW-1:0]       slow);
    interp_result_t r;
    int             used;
    int             k;
    longint         a0, a1, r0, r1, den, value;
    if (op == pwli_pkg::OpLoad) begin
      az_tab[idx]  = az;
      res_tab[idx] = rv;
      return;
    end
    used     = used_entries();
    r.status = pwli_pkg::StOk;
    value    = 0;
    if (slow < min_slow || slow >= max_slow) begin
      r.status = pwli_pkg::StNoTable;
    end else if (az < az_tab[0] || az > az_tab[used-1]) begin
      r.status = pwli_pkg::StAzRange;
    end else begin
      // First breakpoint not below the azimuth.
      k = 1;
      while (k < used && az_tab[k] < az) k++;
      if (k >= used) begin
        r.status = pwli_pkg::StOverrun;
      end else begin
        a0  = az_tab[k-1];
        a1  = az_tab[k];
        r0  = res_tab[k-1];
        r1  = res_tab[k];
        den = a1 - a0;
        // Coincident breakpoints give the left residual; otherwise the
        // quotient truncates toward zero.
        if (den == 0) begin
          value = r0;
        end else begin
          value = r0 + ((longint'(az) - a0) * (r1 - r0)) / den;
        end
        if (value > 32767) value = 32767;
        if (value < -32768) value = -32768;
      end
    end
    r.residual = value[pwli_pkg::ResW-1:0];
    residuals_due.push_back(r);
  endfunction

  task report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  task check_residual(logic signed [pwli_pkg::ResW-1:0] residual,
                      logic [pwli_pkg::StatW-1:0]       status);
    interp_result_t want;
    if (residuals_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result: residual %0d status %0d",
                                residual, status));
      return;
    end
    want = residuals_due.pop_front();
    if (residual !== want.residual)
      report_mismatch($sformatf("residual %0d, predicted %0d",
                                residual, want.residual));
    if (status !== want.status)
      report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
  endtask

endclass

module testbench;

  // Address slot beyond the defined registers.
  localparam logic [1:0] RegSpare    = 2'd3;
  // Longest query latency with some margin.
  localparam int         QuietCycles = 120;
  localparam int         Phases      = 9;

  logic                                 clk_i;
  logic                                 rst_ni           = 1'b0;
  logic                                 in_valid_i       = 1'b0;
  logic [pwli_pkg::OpW-1:0]             op_i             = pwli_pkg::OpLoad;
  logic [pwli_pkg::AddrW-1:0]           entry_index_i    = '0;
  logic signed [pwli_pkg::AzW-1:0]      azimuth_i        = '0;
  logic signed [pwli_pkg::ResW-1:0]     residual_value_i = '0;
  logic [pwli_pkg::SlowW-1:0]           slowness_i       = '0;
  logic                                 out_stall_i      = 1'b0;
  logic                                 psel             = 1'b0;
  logic                                 penable          = 1'b0;
  logic                                 pwrite           = 1'b0;
  logic [pwli_pkg::PaddrW-1:0]          paddr            = '0;
  logic [pwli_pkg::PdataW-1:0]          pwdata           = '0;
  logic                                 in_stall_o;
  logic                                 out_valid_o;
  logic signed [pwli_pkg::ResW-1:0]     residual_o;
  logic [pwli_pkg::StatW-1:0]           status_o;
  logic [pwli_pkg::PdataW-1:0]          prdata;
  logic                                 pready;
  // Set for one phase so that neither side idles.
  logic                                 steady           = 1'b0;

  residual_scoreboard sb;

  piecewise_linear_table_interp_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .entry_index_i    (entry_index_i),
    .azimuth_i        (azimuth_i),
    .residual_value_i (residual_value_i),
    .slowness_i       (slowness_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .residual_o       (residual_o),
    .status_o         (status_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Result side: check each transaction taken and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_residual(residual_o, status_o);
    out_stall_i <= !steady && ($urandom_range(99) < 10);
  end

  // One register write: setup cycle, then access until pready.
  task automatic write_reg(input logic [1:0] index, input int value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(index, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Presents one transaction, with an occasional gap before it, and holds it
  // until the block takes it.
  task automatic send_item(input logic [pwli_pkg::OpW-1:0]         op,
                           input logic [pwli_pkg::AddrW-1:0]       idx,
                           input logic signed [pwli_pkg::AzW-1:0]  az,
                           input logic signed [pwli_pkg::ResW-1:0] rv,
                           input logic [pwli_pkg::SlowW-1:0]       slow);
    int gap;
    if (!steady && $urandom_range(99) < 10) begin
      gap = $urandom_range(8, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    entry_index_i    <= idx;
    azimuth_i        <= az;
    residual_value_i <= rv;
    slowness_i       <= slow;
    do @(posedge clk_i); while (in_stall_o);
    sb.interpolate_item(op, idx, az, rv, slow);
  endtask

  task automatic send_load(input int idx, input int az, input int rv);
    send_item(pwli_pkg::OpLoad, pwli_pkg::AddrW'(idx), pwli_pkg::AzW'(az),
              pwli_pkg::ResW'(rv), pwli_pkg::SlowW'($urandom_range(5000)));
  endtask

  task automatic send_query(input int slow, input int az);
    send_item(pwli_pkg::OpQuery, pwli_pkg::AddrW'($urandom_range(63)),
              pwli_pkg::AzW'(az),
              pwli_pkg::ResW'(int'($urandom_range(65535)) - 32768),
              pwli_pkg::SlowW'(slow));
  endtask

  // Waits for every result due, then for the longest query to finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  initial begin
    int p, k, n, used, items, cnt, s_min, s_max;
    int lo, hi, az, idx, slow, roll, s_lo, s_hi, step_max, pos;
    bit scrambled;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings: two entries, window [0, 5000).
    send_load(0, -36000, -32768);
    send_load(1, 36000, 32767);
    send_load(63, 0, 0);
    send_query(0, -36000);
    send_query(4999, 36000);
    send_query(2500, 0);
    send_query(2500, -35999);
    send_query(5000, 0);
    send_query(5000, 36000);
    // Coincident breakpoints.
    send_load(0, 100, 500);
    send_load(1, 100, -700);
    send_query(100, 100);
    send_query(100, 99);
    send_query(100, 101);
    // Truncation toward zero for a negative and a positive quotient.
    send_load(0, 0, 0);
    send_load(1, 2, -3);
    send_query(7, 1);
    send_load(1, 2, 3);
    send_query(7, 1);
    send_query(7, 2);
    send_query(7, -1);

    for (p = 0; p < Phases; p++) begin
      settle();
      steady <= (p == 1);
      case (p)
        0: begin cnt = 2;   s_min = 0;    s_max = 5000; items = 190; end
        1: begin cnt = 64;  s_min = 0;    s_max = 8191; items = 220; end
        2: begin cnt = 0;   s_min = 100;  s_max = 4000; items = 190; end
        3: begin cnt = 127; s_min = 2500; s_max = 2600; items = 190; end
        4: begin cnt = 5;   s_min = 5000; s_max = 5000; items = 40;  end
        5: begin
          cnt   = $urandom_range(64, 2);
          s_min = $urandom_range(2500);
          s_max = $urandom_range(5000, s_min + 1);
          items = 190;
        end
        6: begin cnt = $urandom_range(12, 3); s_min = 0; s_max = 5000; items = 300; end
        7: begin cnt = 40;  s_min = 4000; s_max = 1000; items = 30;  end
        default: begin
          cnt   = $urandom_range(64, 2);
          s_min = $urandom_range(1000);
          s_max = $urandom_range(5000, 4000);
          items = 250;
        end
      endcase
      write_reg(pwli_pkg::RegEntryCount, cnt);
      write_reg(pwli_pkg::RegMinSlow, s_min);
      write_reg(pwli_pkg::RegMaxSlow, s_max);
      // A write to the unused slot must change nothing.
      if (p == 4) write_reg(RegSpare, int'($urandom));
      used = sb.used_entries();

      // Fresh table over every entry in use: mostly ascending with some
      // repeated breakpoints, now and then in no order at all.
      scrambled = (p == 8) && ($urandom_range(1) == 1);
      step_max  = ($urandom_range(3) == 0) ? 20 : 69000 / (used - 1);
      pos       = -36000 + int'($urandom_range(3000));
      for (k = 0; k < used; k++) begin
        if (scrambled) begin
          az = int'($urandom_range(72000)) - 36000;
        end else begin
          if (k > 0 && $urandom_range(7) != 0) pos += int'($urandom_range(step_max, 1));
          if (pos > 36000) pos = 36000;
          az = pos;
        end
        send_load(k, az, int'($urandom_range(65535)) - 32768);
      end

      // Mixed traffic: mostly queries aimed into the table and window.
      for (n = 0; n < items; n++) begin
        if ($urandom_range(99) < 15) begin
          idx = $urandom_range(63);
          if ($urandom_range(9) < 7) az = sb.az_tab[idx];
          else az = int'($urandom_range(72000)) - 36000;
          send_load(idx, az, int'($urandom_range(65535)) - 32768);
        end else begin
          lo   = sb.az_tab[0];
          hi   = sb.az_tab[used-1];
          roll = $urandom_range(99);
          if (roll < 70 && lo <= hi) az = lo + int'($urandom_range(hi - lo));
          else if (roll < 80) az = sb.az_tab[$urandom_range(used - 1)];
          else if (roll < 90) az = int'($urandom_range(72000)) - 36000;
          else az = ($urandom_range(1) == 1) ? lo - 1 : hi + 1;
          if (az < -36000) az = -36000;
          if (az > 36000) az = 36000;

          s_lo = sb.min_slow;
          s_hi = ((sb.max_slow > 5000) ? 5001 : int'(sb.max_slow)) - 1;
          roll = $urandom_range(99);
          if (roll < 85 && s_lo <= s_hi) begin
            slow = s_lo + int'($urandom_range(s_hi - s_lo));
          end else if (roll < 93) begin
            // Either edge of the window.
            slow = ($urandom_range(1) == 1) ? int'(sb.max_slow) : int'(sb.min_slow) - 1;
            if (slow < 0) slow = 0;
            if (slow > 5000) slow = 5000;
          end else begin
            slow = $urandom_range(5000);
          end
          send_query(slow, az);
        end
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
